// ===== rtl/ftr_pkg.sv =====
// Package for the fixed-point translate/rotate block: word types, register codes
// and saturating arithmetic helpers. Depends on nothing.
package ftr_pkg;

	localparam int WORD_BITS     = 16;
	localparam int FRACTION_BITS = 5;
	localparam int PROD_BITS     = 2 * WORD_BITS;
	localparam int SHIFT_BITS    = PROD_BITS - FRACTION_BITS;
	localparam int REG_COUNT     = 4;
	localparam int INDEX_BITS    = $clog2(REG_COUNT);

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic [INDEX_BITS-1:0] reg_index_t;

	localparam reg_index_t REG_OFFSET_X = INDEX_BITS'(0);
	localparam reg_index_t REG_OFFSET_Y = INDEX_BITS'(1);
	localparam reg_index_t REG_COS_COEF = INDEX_BITS'(2);
	localparam reg_index_t REG_SIN_COEF = INDEX_BITS'(3);

	localparam word_t WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t COS_RESET  = WORD_BITS'(1 << FRACTION_BITS);

	typedef struct packed {
		word_t point_x;
		word_t point_y;
	} point_t;

	typedef struct packed {
		word_t moved_x;
		word_t moved_y;
	} moved_t;

	typedef struct packed {
		word_t offset_x;
		word_t offset_y;
		word_t cos_coef;
		word_t sin_coef;
	} cfg_t;

	// Saturating add or subtract of two words.
	function automatic word_t sat_addsub(word_t a, word_t b, logic sub);
		logic signed [WORD_BITS:0] s;
		s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
		        : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
		if (s[WORD_BITS] != s[WORD_BITS-1])
			return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
		return s[WORD_BITS-1:0];
	endfunction

	// Floor shift of a full product by the fraction bits, then saturate.
	function automatic word_t sat_product(prod_t p);
		logic signed [SHIFT_BITS-1:0] s;
		logic                         ovf;
		s   = SHIFT_BITS'(p >>> FRACTION_BITS);
		ovf = !((&s[SHIFT_BITS-1:WORD_BITS-1]) || !(|s[SHIFT_BITS-1:WORD_BITS-1]));
		if (ovf)
			return s[SHIFT_BITS-1] ? WORD_MIN : WORD_MAX;
		return s[WORD_BITS-1:0];
	endfunction

endpackage

// ===== rtl/fixed_point_translate_rotate_2d.sv =====
// Top level of the fixed-point translate/rotate block: register file and pipeline.
// Depends on ftr_pkg, ftr_translate, ftr_rotate_mul and ftr_combine.
//
// The block takes one point per clock cycle and returns each result from the
// register stages in order: translate, multiply, shift/saturate and combine
// are one register stage each, so one transaction enters and one
// leaves every cycle. busy is never raised. The result is shown for one cycle
// with done high; the receiver cannot stall it, so capture it on that edge.
// Write the registers only while no transaction is in flight.
module fixed_point_translate_rotate_2d
	import ftr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  point_t     point,
	input  logic       wr_en,
	input  reg_index_t wr_index,
	input  word_t      wr_data,
	output logic       done,
	output moved_t     result
);

	cfg_t cfg_q;

	logic   valid_s1, valid_s3, valid_s4;
	point_t point_s1;
	word_t  xc_s3, ys_s3, xs_s3, yc_s3;
	moved_t moved_s4;

	// The pipeline never stalls, so accept a transaction on every start.
	assign busy = 1'b0;

	// Register file: hold values until written; reset to the identity transform.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x <= '0;
			cfg_q.offset_y <= '0;
			cfg_q.cos_coef <= COS_RESET;
			cfg_q.sin_coef <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OFFSET_X: cfg_q.offset_x <= wr_data;
				REG_OFFSET_Y: cfg_q.offset_y <= wr_data;
				REG_COS_COEF: cfg_q.cos_coef <= wr_data;
				REG_SIN_COEF: cfg_q.sin_coef <= wr_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	// Stage 1: add the translation with saturation.
	ftr_translate u_translate (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_point (point),
		.offset_x (cfg_q.offset_x),
		.offset_y (cfg_q.offset_y),
		.valid_s1 (valid_s1),
		.point_s1 (point_s1)
	);

	// Stages 2 and 3: products from the translated point, never the rotated one.
	ftr_rotate_mul u_rotate_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.point_s1 (point_s1),
		.cos_coef (cfg_q.cos_coef),
		.sin_coef (cfg_q.sin_coef),
		.valid_s3 (valid_s3),
		.xc_s3    (xc_s3),
		.ys_s3    (ys_s3),
		.xs_s3    (xs_s3),
		.yc_s3    (yc_s3)
	);

	// Stage 4: combine into the result and drive the output register.
	ftr_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.xc_s3    (xc_s3),
		.ys_s3    (ys_s3),
		.xs_s3    (xs_s3),
		.yc_s3    (yc_s3),
		.valid_s4 (valid_s4),
		.moved_s4 (moved_s4)
	);

	assign done   = valid_s4;
	assign result = moved_s4;

endmodule

// ===== rtl/ftr_translate.sv =====
// Stage 1: saturating translation of the incoming point.
// Depends on ftr_pkg.
module ftr_translate
	import ftr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  point_t in_point,
	input  word_t  offset_x,
	input  word_t  offset_y,
	output logic   valid_s1,
	output point_t point_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		point_s1.point_x <= sat_addsub(in_point.point_x, offset_x, 1'b0);
		point_s1.point_y <= sat_addsub(in_point.point_y, offset_y, 1'b0);
	end

endmodule

// ===== rtl/ftr_rotate_mul.sv =====
// Stages 2 and 3: four full-width products, then floor shift and saturation.
// Depends on ftr_pkg.
module ftr_rotate_mul
	import ftr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   valid_s1,
	input  point_t point_s1,
	input  word_t  cos_coef,
	input  word_t  sin_coef,
	output logic   valid_s3,
	output word_t  xc_s3,
	output word_t  ys_s3,
	output word_t  xs_s3,
	output word_t  yc_s3
);

	logic  valid_s2;
	prod_t xc_s2, ys_s2, xs_s2, yc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Widen both operands first so the product keeps all of its bits.
	always_ff @(posedge clk) begin
		xc_s2 <= prod_t'(point_s1.point_x) * prod_t'(cos_coef);
		ys_s2 <= prod_t'(point_s1.point_y) * prod_t'(sin_coef);
		xs_s2 <= prod_t'(point_s1.point_x) * prod_t'(sin_coef);
		yc_s2 <= prod_t'(point_s1.point_y) * prod_t'(cos_coef);
	end

	always_ff @(posedge clk) begin
		xc_s3 <= sat_product(xc_s2);
		ys_s3 <= sat_product(ys_s2);
		xs_s3 <= sat_product(xs_s2);
		yc_s3 <= sat_product(yc_s2);
	end

endmodule

// ===== rtl/ftr_combine.sv =====
// Stage 4: saturating difference and sum of the products into the result.
// Depends on ftr_pkg.
module ftr_combine
	import ftr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   valid_s3,
	input  word_t  xc_s3,
	input  word_t  ys_s3,
	input  word_t  xs_s3,
	input  word_t  yc_s3,
	output logic   valid_s4,
	output moved_t moved_s4
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		moved_s4.moved_x <= sat_addsub(xc_s3, ys_s3, 1'b1);
		moved_s4.moved_y <= sat_addsub(xs_s3, yc_s3, 1'b0);
	end

endmodule

// ===== rtl/ftr_checker.sv =====
// Port-level checker for the translate/rotate block, bound to the top level.
// Depends on ftr_pkg and fixed_point_translate_rotate_2d.
module ftr_checker
	import ftr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input point_t     point,
	input logic       wr_en,
	input logic       done,
	input moved_t     result
);

	// Every accepted transaction raises done when its result leaves the combine stage.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted transaction gave no result");

	// No result without an accepted transaction behind it in the pipeline.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without a transaction");

	// Equal points under unchanged registers give equal results.
	a_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && $past(point, 4) == $past(point, 5)
			&& !$past(wr_en, 1) && !$past(wr_en, 2) && !$past(wr_en, 3)
			&& !$past(wr_en, 4) && !$past(wr_en, 5) && !$past(wr_en, 6))
		|-> result == $past(result))
		else $error("same point gave a different result");

	// The pipeline never holds off a start.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind fixed_point_translate_rotate_2d ftr_checker u_ftr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.point    (point),
	.wr_en    (wr_en),
	.done     (done),
	.result   (result)
);
